// ----- sv/gqls_pkg.sv -----
// Shared types, constants and helpers for the grid Q-learning step block.
// Used by every module of the block but gqls_ram; depends on nothing.
package gqls_pkg;

    // Grid geometry
    localparam int GRID_SIDE = 4;
    localparam int MOVES     = 4;
    localparam int CELLS     = GRID_SIDE * GRID_SIDE;
    localparam int CELL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COORD_W   = (GRID_SIDE > 4) ? $clog2(GRID_SIDE) : 2;
    localparam int MOVE_W    = 2;

    // Fixed-point widths
    localparam int Q_W      = 16;
    localparam int ROW_W    = MOVES * Q_W;
    localparam int FRAC_SH  = 16;
    localparam int COEF_W   = 17;                   // unsigned Q0.16 with a zero sign bit
    localparam int PROD1_W  = Q_W + COEF_W;         // gamma * maxQ
    localparam int DIFF_W   = 19;                   // r + round(gamma*maxQ) - Q
    localparam int PROD2_W  = DIFF_W + COEF_W;      // alpha * diff
    localparam int DELTA_W  = PROD2_W + 1 - FRAC_SH;
    localparam int NQ_W     = DELTA_W + 1;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Configuration port
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_LEARN_RATE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DISCOUNT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_EXPLORE    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GOAL_REW   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_REW   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GOAL_COL   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GOAL_ROW   = 3'd6;

    localparam logic [15:0] RST_LEARN_RATE = 16'd9830;
    localparam logic [15:0] RST_DISCOUNT   = 16'd64881;
    localparam logic [15:0] RST_EXPLORE    = 16'd9830;
    localparam logic [15:0] RST_GOAL_REW   = 16'd1024;
    localparam logic [15:0] RST_STEP_REW   = 16'hFF9A;  // -102
    localparam logic [1:0]  RST_GOAL_COL   = 2'd3;
    localparam logic [1:0]  RST_GOAL_ROW   = 2'd3;

    // Command, move and status codes
    localparam logic       CMD_PLACE = 1'b0;
    localparam logic       CMD_STEP  = 1'b1;

    localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_UP    = 2'd2;
    localparam logic [MOVE_W-1:0] MOVE_DOWN  = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_PLACED  = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    typedef struct packed {
        logic [15:0]        learn_rate;
        logic [15:0]        discount;
        logic [15:0]        explore_threshold;
        logic signed [15:0] goal_reward;
        logic signed [15:0] step_reward;
        logic [1:0]         goal_col;
        logic [1:0]         goal_row;
    } cfg_t;

    typedef struct packed {
        logic accept;    // latch word, read current cell row
        logic choose;    // pick move, read next cell row
        logic maxq;      // max of next row, reward
        logic mul1;      // gamma * maxQ
        logic diff;      // target - Q
        logic mul2;      // alpha * diff
        logic update;    // saturate, write back, move agent
        logic out_load;  // load output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic step_go;   // offered word is a step that is not refused
    } dp_status_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [1:0] v);
        logic [COORD_W-1:0] ext;
        ext = COORD_W'(v);
        if (ext > COORD_W'(GRID_SIDE - 1)) begin
            return COORD_W'(GRID_SIDE - 1);
        end
        return ext;
    endfunction

    function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] col,
                                                      input logic [COORD_W-1:0] row);
        return CELL_W'(row * GRID_SIDE + col);
    endfunction

endpackage

// ----- sv/gqls_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module gqls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/gqls_cfg.sv -----
// APB register file holding the learning and goal settings.
// Depends on gqls_pkg for the register map and cfg_t.
module gqls_cfg import gqls_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_hit  = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_hit) begin
            unique case (reg_idx)
                REG_LEARN_RATE: cfg_next.learn_rate        = pwdata[15:0];
                REG_DISCOUNT:   cfg_next.discount          = pwdata[15:0];
                REG_EXPLORE:    cfg_next.explore_threshold = pwdata[15:0];
                REG_GOAL_REW:   cfg_next.goal_reward       = pwdata[15:0];
                REG_STEP_REW:   cfg_next.step_reward       = pwdata[15:0];
                REG_GOAL_COL:   cfg_next.goal_col          = pwdata[1:0];
                REG_GOAL_ROW:   cfg_next.goal_row          = pwdata[1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.learn_rate        <= RST_LEARN_RATE;
            cfg_reg.discount          <= RST_DISCOUNT;
            cfg_reg.explore_threshold <= RST_EXPLORE;
            cfg_reg.goal_reward       <= RST_GOAL_REW;
            cfg_reg.step_reward       <= RST_STEP_REW;
            cfg_reg.goal_col          <= RST_GOAL_COL;
            cfg_reg.goal_row          <= RST_GOAL_ROW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEARN_RATE: prdata = {16'd0, cfg_reg.learn_rate};
            REG_DISCOUNT:   prdata = {16'd0, cfg_reg.discount};
            REG_EXPLORE:    prdata = {16'd0, cfg_reg.explore_threshold};
            REG_GOAL_REW:   prdata = CFG_DATA_W'(cfg_reg.goal_reward);
            REG_STEP_REW:   prdata = CFG_DATA_W'(cfg_reg.step_reward);
            REG_GOAL_COL:   prdata = {30'd0, cfg_reg.goal_col};
            REG_GOAL_ROW:   prdata = {30'd0, cfg_reg.goal_row};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/gqls_ctrl.sv -----
// Sequencing state machine: handshakes on both streams and datapath commands.
// Depends on gqls_pkg for ctrl_cmd_t and dp_status_t.
module gqls_ctrl import gqls_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CHOOSE = 3'd1;
    localparam logic [2:0] ST_MAXQ   = 3'd2;
    localparam logic [2:0] ST_MUL1   = 3'd3;
    localparam logic [2:0] ST_DIFF   = 3'd4;
    localparam logic [2:0] ST_MUL2   = 3'd5;
    localparam logic [2:0] ST_UPDATE = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = status.step_go ? ST_CHOOSE : ST_OUT;
                end
            end
            ST_CHOOSE: begin
                cmd.choose = 1'b1;
                state_next = ST_MAXQ;
            end
            ST_MAXQ: begin
                cmd.maxq   = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold until the output register is free or being drained
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- sv/gqls_dp.sv -----
// Datapath: agent position, Q table (one row of four moves per cell),
// move choice, fixed-point update and output register.
// Depends on gqls_pkg and gqls_ram.
module gqls_dp import gqls_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [1:0]           m_tuser
);

    // Input word fields
    logic [1:0]  in_start_col;
    logic [1:0]  in_start_row;
    logic [15:0] in_draw;
    logic [1:0]  in_rmove;

    assign in_start_col = s_tdata[1:0];
    assign in_start_row = s_tdata[3:2];
    assign in_draw      = s_tdata[19:4];
    assign in_rmove     = s_tdata[21:20];

    // Agent and per-row valid bits
    logic [COORD_W-1:0] agent_col_reg;
    logic [COORD_W-1:0] agent_row_reg;
    logic [CELLS-1:0]   row_valid_reg;

    logic [COORD_W-1:0] goal_col_c;
    logic [COORD_W-1:0] goal_row_c;
    logic               agent_on_goal;

    assign goal_col_c    = clamp_coord(cfg.goal_col);
    assign goal_row_c    = clamp_coord(cfg.goal_row);
    assign agent_on_goal = (agent_col_reg == goal_col_c) && (agent_row_reg == goal_row_c);
    assign status.step_go = (s_tuser == CMD_STEP) && !agent_on_goal;

    // Item working registers
    logic [15:0]              draw_reg;
    logic [MOVE_W-1:0]        rmove_reg;
    logic [MOVE_W-1:0]        move_reg;
    logic [COORD_W-1:0]       new_col_reg;
    logic [COORD_W-1:0]       new_row_reg;
    logic [ROW_W-1:0]         old_row_reg;
    logic signed [Q_W-1:0]    q_old_reg;
    logic signed [Q_W-1:0]    best_next_reg;
    logic signed [Q_W-1:0]    reward_reg;
    logic signed [PROD1_W-1:0] prod1_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD2_W-1:0] prod2_reg;

    // Result registers
    logic [1:0]            res_status_reg;
    logic [MOVE_W-1:0]     res_move_reg;
    logic signed [Q_W-1:0] res_reward_reg;
    logic signed [Q_W-1:0] res_value_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    // Table access
    logic              rd_en;
    logic [CELL_W-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_row;
    logic              rd_valid_reg;
    logic [ROW_W-1:0]  eff_row;
    logic [CELL_W-1:0] old_cell;
    logic [ROW_W-1:0]  wr_row;

    logic signed [Q_W-1:0] q_cur [MOVES];
    logic signed [Q_W-1:0] best_q;
    logic [MOVE_W-1:0]     best_m;
    logic                  explore;
    logic [MOVE_W-1:0]     move_sel;
    logic [COORD_W-1:0]    next_col;
    logic [COORD_W-1:0]    next_row;

    logic signed [PROD1_W:0]   p1_bias;
    logic signed [PROD1_W-FRAC_SH:0] p1_rnd;
    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [PROD2_W:0]   p2_bias;
    logic signed [DELTA_W-1:0] delta;
    logic signed [NQ_W-1:0]    nq;
    logic signed [Q_W-1:0]     nq_sat;

    assign old_cell = cell_index(agent_col_reg, agent_row_reg);
    assign rd_en    = cmd.accept || cmd.choose;
    assign rd_addr  = cmd.choose ? cell_index(next_col, next_row) : old_cell;
    assign eff_row  = rd_valid_reg ? rd_row : '0;

    gqls_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CELLS)
    ) u_qtab (
        .aclk    (aclk),
        .wr_en   (cmd.update),
        .wr_addr (old_cell),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    // First move with the largest value of the row just read
    always_comb begin
        for (int m = 0; m < MOVES; m++) begin
            q_cur[m] = eff_row[m*Q_W +: Q_W];
        end
        best_q = q_cur[0];
        best_m = MOVE_RIGHT;
        for (int m = 1; m < MOVES; m++) begin
            if (q_cur[m] > best_q) begin
                best_q = q_cur[m];
                best_m = MOVE_W'(m);
            end
        end
    end

    assign explore  = (draw_reg < cfg.explore_threshold);
    assign move_sel = explore ? rmove_reg : best_m;

    // Move and stop at the edges
    always_comb begin
        next_col = agent_col_reg;
        next_row = agent_row_reg;
        unique case (move_sel)
            MOVE_RIGHT: if (agent_col_reg < COORD_W'(GRID_SIDE - 1)) next_col = agent_col_reg + 1'b1;
            MOVE_LEFT:  if (agent_col_reg != '0) next_col = agent_col_reg - 1'b1;
            MOVE_UP:    if (agent_row_reg != '0) next_row = agent_row_reg - 1'b1;
            MOVE_DOWN:  if (agent_row_reg < COORD_W'(GRID_SIDE - 1)) next_row = agent_row_reg + 1'b1;
            default:    next_col = agent_col_reg;
        endcase
    end

    // Round half up on the Q0.16 products
    assign p1_bias   = (PROD1_W+1)'(prod1_reg) + (PROD1_W+1)'(32768);
    assign p1_rnd    = (PROD1_W-FRAC_SH+1)'(p1_bias >>> FRAC_SH);
    assign diff_next = DIFF_W'(reward_reg) + DIFF_W'(p1_rnd) - DIFF_W'(q_old_reg);
    assign p2_bias   = (PROD2_W+1)'(prod2_reg) + (PROD2_W+1)'(32768);
    assign delta     = DELTA_W'(p2_bias >>> FRAC_SH);
    assign nq        = NQ_W'(q_old_reg) + NQ_W'(delta);

    always_comb begin
        priority if (nq > NQ_W'(32767)) begin
            nq_sat = 16'sh7FFF;
        end else if (nq < -NQ_W'(32768)) begin
            nq_sat = -16'sh8000;
        end else begin
            nq_sat = nq[Q_W-1:0];
        end
    end

    always_comb begin
        wr_row = old_row_reg;
        wr_row[move_reg*Q_W +: Q_W] = nq_sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            agent_col_reg <= '0;
            agent_row_reg <= '0;
            row_valid_reg <= '0;
        end else begin
            if (cmd.accept && (s_tuser == CMD_PLACE)) begin
                agent_col_reg <= clamp_coord(in_start_col);
                agent_row_reg <= clamp_coord(in_start_row);
            end else if (cmd.update) begin
                agent_col_reg <= new_col_reg;
                agent_row_reg <= new_row_reg;
                row_valid_reg[old_cell] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (cmd.accept) begin
            draw_reg       <= in_draw;
            rmove_reg      <= in_rmove;
            res_status_reg <= (s_tuser == CMD_PLACE) ? STAT_PLACED : STAT_REFUSED;
            res_move_reg   <= MOVE_RIGHT;
            res_reward_reg <= '0;
            res_value_reg  <= '0;
        end
        if (cmd.choose) begin
            move_reg    <= move_sel;
            new_col_reg <= next_col;
            new_row_reg <= next_row;
            old_row_reg <= eff_row;
            q_old_reg   <= q_cur[move_sel];
        end
        if (cmd.maxq) begin
            best_next_reg <= best_q;
            reward_reg    <= ((new_col_reg == goal_col_c) && (new_row_reg == goal_row_c))
                             ? cfg.goal_reward : cfg.step_reward;
        end
        if (cmd.mul1) begin
            prod1_reg <= best_next_reg * $signed({1'b0, cfg.discount});
        end
        if (cmd.diff) begin
            diff_reg <= diff_next;
        end
        if (cmd.mul2) begin
            prod2_reg <= diff_reg * $signed({1'b0, cfg.learn_rate});
        end
        if (cmd.update) begin
            res_status_reg <= STAT_DONE;
            res_move_reg   <= move_reg;
            res_reward_reg <= reward_reg;
            res_value_reg  <= nq_sat;
        end
        if (cmd.out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {1'b0, agent_on_goal, res_value_reg, res_reward_reg,
                            agent_row_reg[1:0], agent_col_reg[1:0], res_move_reg};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ----- sv/gridworld_q_learning_step_top.sv -----
// Grid Q-learning step: place and step commands on a stream, APB settings.
// Output: m_tvalid rises once the word has passed ST_OUT (place or refused step) or
// ST_CHOOSE, ST_MAXQ, ST_MUL1, ST_DIFF, ST_MUL2, ST_UPDATE and ST_OUT (learning step).
// One word at a time: the next word is taken only back in ST_IDLE, after ST_OUT (place)
// or after the two row reads of the table and the two chained multiplies (step).
// Reset (aresetn, synchronous, active low): agent at cell (0,0), settings to defaults,
// all table rows read as zero through per-row valid bits; no clearing pass.
module gridworld_q_learning_step_top import gqls_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // start_col[1:0], start_row[3:2], random_draw[19:4], random_move[21:20]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chosen_move[1:0], new_col[3:2], new_row[5:4], step_reward_out[21:6],
    // updated_value[37:22], at_goal[38]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [1:0]            m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    gqls_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gqls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gqls_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser[0]),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // one word in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("word accepted while previous word still in progress");

    // a place with a free output register is not held in ST_OUT before its result is shown
    a_place_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == CMD_PLACE) && (!m_tvalid || m_tready))
        |=> ##1 m_tvalid)
        else $error("place result not presented in time");

    // a refused step happens only at the goal and reports no move or update
    a_refused_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STAT_REFUSED))
        |-> (m_tdata[38] && (m_tdata[1:0] == MOVE_RIGHT) && (m_tdata[37:22] == '0)))
        else $error("refused step word carries move, update or off-goal flag");

    // the table is only written during a step, never while waiting for a word
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> (!s_tready && !cmd.out_load))
        else $error("table write outside the update phase");

endmodule
